FILE: hdl/rsrs_pkg.sv
// Package for the RAID-0 stripe request splitter.
// Item types, status codes, controller states and the command/status structs.
// No dependencies.
package rsrs_pkg;

  localparam int COUNT_W = 15;

  localparam logic [1:0] ST_SEGMENT = 2'd0;
  localparam logic [1:0] ST_UNBOUND = 2'd1;
  localparam logic [1:0] ST_PASTEND = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] byte_offset;
    logic [14:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic        disk_select;
    logic [30:0] disk_offset;
    logic [10:0] segment_length;
    logic [13:0] buffer_position;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_DIVIDE = 6'b000100,
    S_MULT   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_SINGLE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mult;
    logic emit;
    logic emit_single;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic div_done;
    logic seg_last;
    logic seg_wrap;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/rsrs_divider.sv
// Block split of the volume offset by shift and mask: block number and offset within block.
// BLOCK_BYTES must be a power of two; the block does not check it. Uses no package items.
module rsrs_divider #(
  parameter int BLOCK_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    dividend,
  output logic                           done,
  output logic [31:0]                    quotient,
  output logic [$clog2(BLOCK_BYTES)-1:0] remainder
);

  localparam int IW = $clog2(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend >> IW;
      remainder <= dividend[IW-1:0];
    end
  end

endmodule

FILE: hdl/rsrs_datapath.sv
// Datapath: request registers, stored length, disk offset arithmetic, output register.
// Depends on rsrs_pkg and rsrs_divider.
module rsrs_datapath #(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAX_REQUEST = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  rsrs_pkg::cmd_t     cmd,
  output rsrs_pkg::sts_t     sts,
  input  rsrs_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsrs_pkg::out_item_t out_data
);

  localparam int CW = rsrs_pkg::COUNT_W;
  localparam int IW = $clog2(BLOCK_BYTES);
  localparam int NW = $clog2(BLOCK_BYTES + 1);
  localparam int LW = (NW > CW) ? NW : CW;
  localparam logic [LW-1:0] BB_L  = LW'(BLOCK_BYTES);
  localparam logic [30:0]   BB31  = 31'(BLOCK_BYTES);
  localparam logic [16:0]   MAXR  = 17'(MAX_REQUEST);

  logic          disks_bound;
  logic [31:0]   stored_length;
  logic [31:0]   offset;
  logic [CW-1:0] count;
  logic [13:0]   pos;
  logic          single;
  logic [1:0]    single_status;
  logic          disk;
  logic [30:0]   base;
  logic [IW-1:0] inblk;

  logic          div_done;
  logic [31:0]   div_q;
  logic [IW-1:0] div_r;

  // load-time checks on the incoming item
  logic [16:0] cnt_c;
  logic [32:0] grown;
  logic        past_end;
  logic [31:0] offset_in;

  always_comb begin
    cnt_c     = ({2'b00, in_data.byte_count} > MAXR) ? MAXR : {2'b00, in_data.byte_count};
    grown     = {1'b0, stored_length} + 33'(cnt_c);
    past_end  = in_data.byte_offset > stored_length;
    offset_in = (in_data.operation && past_end) ? stored_length : in_data.byte_offset;
  end

  // segment arithmetic
  logic [LW-1:0] room;
  logic [LW-1:0] cnt_l;
  logic [LW-1:0] n;
  logic [32:0]   sum;
  logic [30:0]   mult_lo;

  always_comb begin
    room    = BB_L - LW'(inblk);
    cnt_l   = LW'(count);
    n       = (room > cnt_l) ? cnt_l : room;
    sum     = {1'b0, offset} + 33'(n);
    mult_lo = div_q[31:1] * BB31;
  end

  assign sts.single   = single;
  assign sts.div_done = div_done;
  assign sts.seg_last = (cnt_l == n);
  assign sts.seg_wrap = sum[32];
  assign sts.out_free = !out_valid || !out_stall;

  rsrs_divider #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (offset),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      disks_bound   <= 1'b0;
      stored_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        disks_bound <= cfg_data;
      end
      if (cmd.load && disks_bound && in_data.operation) begin
        stored_length <= grown[32] ? 32'hFFFF_FFFF : grown[31:0];
      end
      if (cmd.emit || cmd.emit_single) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset <= offset_in;
      count  <= cnt_c[CW-1:0];
      pos    <= '0;
      if (!disks_bound) begin
        single        <= 1'b1;
        single_status <= rsrs_pkg::ST_UNBOUND;
      end else if (!in_data.operation && past_end) begin
        single        <= 1'b1;
        single_status <= rsrs_pkg::ST_PASTEND;
      end else begin
        single        <= (cnt_c == '0);
        single_status <= rsrs_pkg::ST_SEGMENT;
      end
    end
    if (cmd.mult) begin
      base  <= mult_lo;
      disk  <= div_q[0];
      inblk <= div_r;
    end
    if (cmd.emit) begin
      count  <= count - CW'(n);
      pos    <= pos + 14'(n);
      offset <= sum[31:0];
      inblk  <= '0;
      disk   <= !disk;
      if (disk) begin
        base <= base + BB31;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.disk_select     <= disk;
      out_data.disk_offset     <= base + 31'(inblk);
      out_data.segment_length  <= 11'(n);
      out_data.buffer_position <= pos;
      out_data.status          <= rsrs_pkg::ST_SEGMENT;
      out_data.last            <= (cnt_l == n);
    end else if (cmd.emit_single) begin
      out_data.disk_select     <= 1'b0;
      out_data.disk_offset     <= '0;
      out_data.segment_length  <= '0;
      out_data.buffer_position <= '0;
      out_data.status          <= single_status;
      out_data.last            <= 1'b1;
    end
  end

endmodule

FILE: hdl/rsrs_ctrl.sv
// Controller state machine for the stripe request splitter.
// Depends on rsrs_pkg; drives the datapath by command struct.
module rsrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output rsrs_pkg::cmd_t cmd,
  input  rsrs_pkg::sts_t sts
);

  rsrs_pkg::state_t state;
  rsrs_pkg::state_t state_next;

  assign in_stall = (state != rsrs_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      rsrs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rsrs_pkg::S_START;
        end
      end
      rsrs_pkg::S_START: begin
        if (sts.single) begin
          state_next = rsrs_pkg::S_SINGLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = rsrs_pkg::S_DIVIDE;
        end
      end
      rsrs_pkg::S_DIVIDE: begin
        if (sts.div_done) begin
          state_next = rsrs_pkg::S_MULT;
        end
      end
      rsrs_pkg::S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = rsrs_pkg::S_EMIT;
      end
      rsrs_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.seg_last) begin
            state_next = rsrs_pkg::S_IDLE;
          end else if (sts.seg_wrap) begin
            // volume offset wrapped: block alignment lost, divide again
            state_next = rsrs_pkg::S_START;
          end
        end
      end
      rsrs_pkg::S_SINGLE: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = rsrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rsrs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsrs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/raid0_stripe_request_splitter_unit.sv
// RAID-0 two-disk stripe request splitter, top level. One item at a time.
// Status-only results (not bound, past end, zero count): load, then the status result is emitted.
// Segmented request: load, block split and disk base come first; then segments follow at one a
// cycle while the output is free (up to 17); a wrap past 2^32 redoes block split and disk base.
// Reset (synchronous): stored length 0, disks unbound, controller idle, output empty.
module raid0_stripe_request_splitter_unit #(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAX_REQUEST = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsrs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  rsrs_pkg::cmd_t cmd;
  rsrs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rsrs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  rsrs_datapath #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_REQUEST(MAX_REQUEST)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // an accepted item keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_single) |-> sts.out_free)
    else $error("result loaded over a waiting item");

  // status-only results are always the last of their request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != rsrs_pkg::ST_SEGMENT) |-> out_data.last)
    else $error("status result without last");

endmodule
